// ===== rtl/vslp_pkg.sv =====
// ----------------------------------------------------------------------------
// Variable step low-pass filter package
// Shared widths, register indexes, reset values and transfer types.
// ----------------------------------------------------------------------------
package vslp_pkg;

  localparam int unsigned StampWidth    = 24;
  localparam int unsigned SampleWidth   = 32;
  localparam int unsigned AlphaWidth    = 16;
  localparam int unsigned CfgIndexWidth = 8;

  localparam logic [StampWidth-1:0] StampMax          = 24'hFFFFFF;
  localparam logic [StampWidth-1:0] TimeConstantReset = 24'd1050000;
  localparam logic [StampWidth-1:0] GapLimitReset     = 24'd6300000;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] RegTimeConstant = 8'd0;
  localparam logic [CfgIndexWidth-1:0] RegGapLimit     = 8'd1;

  // Item classified by the front end, waiting for the arithmetic back end
  typedef struct packed {
    logic signed [SampleWidth-1:0] sample;
    logic [StampWidth-1:0]         elapsed;
    logic                          restart;
  } item_t;

  // Finished result
  typedef struct packed {
    logic signed [SampleWidth-1:0] filtered;
    logic                          restarted;
  } result_t;

endpackage

// ===== rtl/vslp_queue.sv =====
// ----------------------------------------------------------------------------
// Small synchronous queue
// First-in first-out register queue with full and empty flags.
// ----------------------------------------------------------------------------
module vslp_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  logic [Width-1:0]    entry_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntWidth'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/vslp_front.sv =====
// ----------------------------------------------------------------------------
// Variable step low-pass filter front end
// Accepts samples, derives elapsed ticks and flags gap restarts.
// ----------------------------------------------------------------------------
module vslp_front import vslp_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic [StampWidth-1:0]         timestamp_i,
  input  logic [StampWidth-1:0]         gap_limit_i,
  input  logic                          queue_full_i,
  output logic                          queue_push_o,
  output item_t                         queue_item_o
);

  logic [StampWidth-1:0] last_stamp_q, last_stamp_d;
  logic [StampWidth-1:0] elapsed;
  logic                  accept;

  assign accept = push_i && !queue_full_i;

  // Down-counting timer: wrap through the full range when the stamp did not drop
  always_comb begin
    if (timestamp_i < last_stamp_q) begin
      elapsed = last_stamp_q - timestamp_i;
    end else begin
      elapsed = StampMax - timestamp_i + last_stamp_q;
    end
  end

  assign last_stamp_d = accept ? timestamp_i : last_stamp_q;

  assign queue_push_o         = accept;
  assign queue_item_o.sample  = sample_i;
  assign queue_item_o.elapsed = elapsed;
  assign queue_item_o.restart = (elapsed > gap_limit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stamp_q <= '0;
    end else begin
      last_stamp_q <= last_stamp_d;
    end
  end

endmodule

// ===== rtl/vslp_back.sv =====
// ----------------------------------------------------------------------------
// Variable step low-pass filter back end
// Serial alpha divider, blend multiplier and output state.
// ----------------------------------------------------------------------------
module vslp_back import vslp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  item_t                 item_i,
  input  logic                  item_empty_i,
  output logic                  item_pop_o,
  input  logic [StampWidth-1:0] time_constant_i,
  input  logic                  out_full_i,
  output logic                  out_push_o,
  output result_t               out_data_o
);

  localparam int unsigned DenWidth  = StampWidth + 1;
  localparam int unsigned DiffWidth = SampleWidth + 1;
  localparam int unsigned ProdWidth = AlphaWidth + 1 + DiffWidth;
  localparam int unsigned CntWidth  = $clog2(AlphaWidth);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StSum  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  localparam logic signed [ProdWidth-1:0] RoundHalf = ProdWidth'(1) <<< (AlphaWidth - 1);

  logic [2:0]                    state_q, state_d;
  logic [CntWidth-1:0]           cnt_q;
  logic [DenWidth-1:0]           den_q;
  logic [DenWidth-1:0]           rem_q;
  logic [AlphaWidth-1:0]         quo_q;
  logic                          sat_q;
  logic signed [SampleWidth-1:0] x_q;
  logic signed [ProdWidth-1:0]   prod_q;
  logic signed [SampleWidth-1:0] y_q;
  logic                          restart_q;
  logic signed [SampleWidth-1:0] last_q;

  logic [DenWidth:0]             rem_shift;
  logic                          rem_ge;
  logic [DenWidth-1:0]           rem_next;
  logic [AlphaWidth-1:0]         alpha;
  logic signed [DiffWidth-1:0]   diff;
  logic signed [ProdWidth-1:0]   prod;
  logic signed [ProdWidth-1:0]   rounded;
  logic signed [ProdWidth-1:0]   scaled;
  logic signed [SampleWidth-1:0] y_sum;

  // One restoring division step per cycle
  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, den_q});
  assign rem_next  = rem_ge ? DenWidth'(rem_shift - {1'b0, den_q}) : DenWidth'(rem_shift);

  // Zero elapsed gives alpha of one, saturated
  assign alpha = sat_q ? '1 : quo_q;

  // y = x + alpha * (y_prev - x), rounded half up
  assign diff    = DiffWidth'(last_q) - DiffWidth'(x_q);
  assign prod    = $signed({{(ProdWidth - AlphaWidth){1'b0}}, alpha})
                 * $signed({{(ProdWidth - DiffWidth){diff[DiffWidth-1]}}, diff});
  assign rounded = prod_q + RoundHalf;
  assign scaled  = rounded >>> AlphaWidth;
  assign y_sum   = x_q + scaled[SampleWidth-1:0];

  assign item_pop_o = (state_q == StIdle) && !item_empty_i;
  assign out_push_o = (state_q == StOut) && !out_full_i;
  assign out_data_o.filtered  = y_q;
  assign out_data_o.restarted = restart_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (!item_empty_i) begin
          state_d = item_i.restart ? StOut : StDiv;
        end
      end
      StDiv: begin
        if (cnt_q == CntWidth'(AlphaWidth - 1)) begin
          state_d = StMul;
        end
      end
      StMul:   state_d = StSum;
      StSum:   state_d = StOut;
      StOut: begin
        if (!out_full_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      if (item_pop_o && item_i.restart) begin
        last_q <= item_i.sample;
      end else if (state_q == StSum) begin
        last_q <= y_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        x_q       <= item_i.sample;
        restart_q <= item_i.restart;
        y_q       <= item_i.sample;
        den_q     <= DenWidth'(time_constant_i) + DenWidth'(item_i.elapsed);
        rem_q     <= DenWidth'(time_constant_i);
        sat_q     <= (item_i.elapsed == '0);
        quo_q     <= '0;
        cnt_q     <= '0;
      end
      StDiv: begin
        rem_q <= rem_next;
        quo_q <= {quo_q[AlphaWidth-2:0], rem_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      StMul:   prod_q <= prod;
      StSum:   y_q <= y_sum;
      default: ;
    endcase
  end

endmodule

// ===== rtl/variable_step_lowpass_filter.sv =====
// ----------------------------------------------------------------------------
// Variable step low-pass filter
// First-order IIR low-pass with alpha = Tf / (Tf + dt) from timer stamps.
// ----------------------------------------------------------------------------
// Flow: the front end queues each push; the back end pops one item at a time,
//   runs the 16-step serial divider that forms alpha, multiplies, sums, and
//   holds the result until the output queue has room; a restart skips the
//   divider. The back end takes no new item until its result is pushed.
// Reset: clears both queues, the last timestamp and last output to zero, and
//   loads the time constant and gap limit registers with their defaults.
// ----------------------------------------------------------------------------
module variable_step_lowpass_filter import vslp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2,
  parameter int unsigned OUT_DEPTH   = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input side
  input  logic                          push,
  output logic                          full,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic [StampWidth-1:0]         timestamp_i,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SampleWidth-1:0] filtered_o,
  output logic                          restarted_o,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CfgIndexWidth-1:0]      cfg_index_i,
  input  logic [StampWidth-1:0]         cfg_data_i
);

  logic [StampWidth-1:0] time_constant_q;
  logic [StampWidth-1:0] gap_limit_q;

  logic    mid_push, mid_full, mid_pop, mid_empty;
  item_t   mid_in, mid_out;
  logic    res_push, res_full;
  result_t res_in, res_out;

  // Configuration: always ready; writes to unknown indexes drop silently
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_constant_q <= TimeConstantReset;
      gap_limit_q     <= GapLimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegTimeConstant) begin
        time_constant_q <= cfg_data_i;
      end else if (cfg_index_i == RegGapLimit) begin
        gap_limit_q <= cfg_data_i;
      end
    end
  end

  // Front end: take the transfer, compute elapsed ticks, classify restarts.
  // The last timestamp advances here, so the back end never sees it.
  vslp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .sample_i     (sample_i),
    .timestamp_i  (timestamp_i),
    .gap_limit_i  (gap_limit_q),
    .queue_full_i (mid_full),
    .queue_push_o (mid_push),
    .queue_item_o (mid_in)
  );

  assign full = mid_full;

  // Decoupling queue between the front and back ends
  vslp_queue #(
    .Width ($bits(item_t)),
    .Depth (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  // Back end: divide for alpha, blend with the previous output, hold the result
  // until the output queue has room.
  vslp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (mid_out),
    .item_empty_i    (mid_empty),
    .item_pop_o      (mid_pop),
    .time_constant_i (time_constant_q),
    .out_full_i      (res_full),
    .out_push_o      (res_push),
    .out_data_o      (res_in)
  );

  // Output queue: parts the back end from the consumer's pop
  vslp_queue #(
    .Width ($bits(result_t)),
    .Depth (OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign filtered_o  = res_out.filtered;
  assign restarted_o = res_out.restarted;

endmodule

// ===== rtl/vslp_checker.sv =====
// ----------------------------------------------------------------------------
// Variable step low-pass filter port checker
// Watches the top-level ports for queue and configuration behavior.
// ----------------------------------------------------------------------------
module vslp_checker import vslp_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          push_i,
  input logic                          full_i,
  input logic                          empty_i,
  input logic                          pop_i,
  input logic signed [SampleWidth-1:0] filtered_i,
  input logic                          restarted_i,
  input logic                          cfg_ready_i
);

  // A waiting result holds until it is popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !pop_i) |=> (!empty_i && $stable(filtered_i) && $stable(restarted_i)))
    else $error("result changed while stalled");

  // The input queue fills only through a push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_i) |-> $past(push_i))
    else $error("full rose without a push");

  // Coming out of reset nothing is queued
  assert property (@(posedge clk_i)
    (rst_ni && $past(!rst_ni)) |-> (empty_i && !full_i))
    else $error("queues not empty after reset");

  // Configuration never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port not ready");

endmodule

bind variable_step_lowpass_filter vslp_checker u_vslp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push_i      (push),
  .full_i      (full),
  .empty_i     (empty),
  .pop_i       (pop),
  .filtered_i  (filtered_o),
  .restarted_i (restarted_o),
  .cfg_ready_i (cfg_ready_o)
);
